/* src/jav_pkg.sv */
// Shared types, constants and register indexes of the jerk, acceleration and velocity limiter.
package jav_pkg;

  localparam int VelW  = 32;
  localparam int DtW   = 24;
  localparam int MaskW = 3;
  localparam int CfgIdxW = 3;

  localparam logic signed [31:0] OneQ16 = 32'sd65536;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegEnableMask   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegVelocityFloor = 3'd1;
  localparam logic [CfgIdxW-1:0] RegVelocityCeil  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAccelFloor    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAccelCeil     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegJerkFloor     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegJerkCeil      = 3'd6;

  // Divider pipeline depth, one quotient bit per stage.
  localparam int DivBits = 49;

  typedef struct packed {
    logic signed [VelW-1:0] requested_velocity;
    logic signed [VelW-1:0] previous_velocity;
    logic signed [VelW-1:0] older_velocity;
    logic        [DtW-1:0]  time_step;
  } jav_in_t;

  typedef struct packed {
    logic signed [VelW-1:0] limited_velocity;
    logic signed [VelW-1:0] scale_factor;
  } jav_out_t;

  typedef struct packed {
    logic [MaskW-1:0]       enable_mask;
    logic signed [VelW-1:0] velocity_floor;
    logic signed [VelW-1:0] velocity_ceiling;
    logic signed [VelW-1:0] accel_floor;
    logic signed [VelW-1:0] accel_ceiling;
    logic signed [VelW-1:0] jerk_floor;
    logic signed [VelW-1:0] jerk_ceiling;
  } jav_cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // Round to nearest with ties up, then drop 16 fraction bits.
  function automatic logic signed [65:0] rnd16(input logic signed [65:0] x);
    logic signed [65:0] y;
    y = x + 66'sd32768;
    return y >>> 16;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    if (v < lo) begin
      return lo;
    end else if (hi < v) begin
      return hi;
    end
    return v;
  endfunction

endpackage

/* src/jav_stream_if.sv */
// Valid/ready channel carrying one payload of a parametric type.
interface jav_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/jerk_accel_velocity_limiter.sv */
// Top level of the jerk, acceleration and velocity limiter.
// Usage: each request on the in_ channel carries a requested velocity, the
// two previously commanded velocities and the time step. The block applies
// the jerk, acceleration and velocity limits that enable_mask switches on, and
// returns one request on the out_ channel with the limited velocity and the
// ratio of limited to requested velocity (one when the request is zero).
// Configuration is written through cfg_we, cfg_index and cfg_wdata while the
// block is idle; unknown indexes are ignored, and only bits 2:0 of the mask
// are kept.
// Throughput is one request per cycle while out_ready does not stall the output.
// Each request passes the limit stages, then the ratio divider, which resolves
// one quotient bit per stage, then the output register.
// Reset clears the configuration registers to zero and empties the pipeline.
// The whole pipeline advances only when its output register is free or being
// drained, so a stall on out_ready holds every request in place and loses or
// repeats nothing; in_ready then falls in the same cycle.
module jerk_accel_velocity_limiter (
  input  logic                        clk,
  input  logic                        rst_n,
  jav_stream_if.sink                  in_if,
  jav_stream_if.source                out_if,
  input  logic                        cfg_we,
  input  logic [jav_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [jav_pkg::VelW-1:0]    cfg_wdata
);
  import jav_pkg::*;

  jav_cfg_t cfg_r;
  logic     adv;
  logic     core_vld, div_vld;
  logic signed [31:0] core_req, core_vel;
  jav_out_t div_item;
  logic     out_vld_r;
  jav_out_t out_r;

  // The pipeline moves when the output register can take what falls out.
  assign adv         = !out_vld_r || out_if.ready;
  assign in_if.ready = adv;
  assign out_if.valid = out_vld_r;
  assign out_if.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegEnableMask:    cfg_r.enable_mask      <= cfg_wdata[MaskW-1:0];
        RegVelocityFloor: cfg_r.velocity_floor   <= cfg_wdata;
        RegVelocityCeil:  cfg_r.velocity_ceiling <= cfg_wdata;
        RegAccelFloor:    cfg_r.accel_floor      <= cfg_wdata;
        RegAccelCeil:     cfg_r.accel_ceiling    <= cfg_wdata;
        RegJerkFloor:     cfg_r.jerk_floor       <= cfg_wdata;
        RegJerkCeil:      cfg_r.jerk_ceiling     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  jav_limit_core u_core (
    .clk, .rst_n, .adv,
    .in_vld(in_if.valid), .in_item(in_if.data), .cfg(cfg_r),
    .out_vld(core_vld), .out_req(core_req), .out_vel(core_vel)
  );

  jav_ratio_div u_div (
    .clk, .rst_n, .adv,
    .in_vld(core_vld), .in_req(core_req), .in_vel(core_vel),
    .out_vld(div_vld), .out_item(div_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= div_item;
    end
  end
endmodule

/* src/jav_limit_core.sv */
// Limit stages: window products, jerk clamp, acceleration clamp and velocity clamp.
module jav_limit_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_vld,
  input  jav_pkg::jav_in_t           in_item,
  input  jav_pkg::jav_cfg_t          cfg,
  output logic                       out_vld,
  output logic signed [31:0]         out_req,
  output logic signed [31:0]         out_vel
);
  import jav_pkg::*;

  // Stage 1: 2*dt^2 window and differences.
  logic              s1_vld_r;
  jav_in_t           s1_in_r;
  logic signed [31:0] s1_dt2_r, s1_dv_r, s1_dv0_r;
  // Stage 2: scaled limits.
  logic              s2_vld_r;
  jav_in_t           s2_in_r;
  logic signed [31:0] s2_dv_r, s2_dv0_r, s2_jlo_r, s2_jhi_r, s2_alo_r, s2_ahi_r;
  // Stage 3: jerk limited velocity.
  logic              s3_vld_r;
  jav_in_t           s3_in_r;
  logic signed [31:0] s3_v_r, s3_alo_r, s3_ahi_r;
  // Stage 4: acceleration and velocity limits.
  logic              s4_vld_r;
  logic signed [31:0] s4_req_r, s4_v_r;

  logic [47:0]        dtsq;
  logic signed [31:0] dt2_nxt, da_nxt, vj_nxt, va_nxt, vf_nxt, dva;
  logic signed [65:0] jlo_p, jhi_p, alo_p, ahi_p;

  always_comb begin
    dtsq    = in_item.time_step * in_item.time_step;
    dt2_nxt = sat32(rnd16({17'd0, dtsq, 1'b0}));
    jlo_p   = 66'(s1_dt2_r) * 66'(cfg.jerk_floor);
    jhi_p   = 66'(s1_dt2_r) * 66'(cfg.jerk_ceiling);
    alo_p   = 66'(cfg.accel_floor) * $signed({42'd0, s1_in_r.time_step});
    ahi_p   = 66'(cfg.accel_ceiling) * $signed({42'd0, s1_in_r.time_step});
    da_nxt  = clamp32(sat32(66'(s2_dv_r) - 66'(s2_dv0_r)), s2_jlo_r, s2_jhi_r);
    vj_nxt  = cfg.enable_mask[2]
            ? sat32(66'(s2_in_r.previous_velocity) + 66'(s2_dv0_r) + 66'(da_nxt))
            : s2_in_r.requested_velocity;
    dva     = clamp32(sat32(66'(s3_v_r) - 66'(s3_in_r.previous_velocity)),
                      s3_alo_r, s3_ahi_r);
    va_nxt  = cfg.enable_mask[1]
            ? sat32(66'(s3_in_r.previous_velocity) + 66'(dva)) : s3_v_r;
    vf_nxt  = cfg.enable_mask[0]
            ? clamp32(va_nxt, cfg.velocity_floor, cfg.velocity_ceiling) : va_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_in_r  <= in_item;
      s1_dt2_r <= dt2_nxt;
      s1_dv_r  <= sat32(66'(in_item.requested_velocity) - 66'(in_item.previous_velocity));
      s1_dv0_r <= sat32(66'(in_item.previous_velocity) - 66'(in_item.older_velocity));
      s2_in_r  <= s1_in_r;
      s2_dv_r  <= s1_dv_r;
      s2_dv0_r <= s1_dv0_r;
      s2_jlo_r <= sat32(rnd16(jlo_p));
      s2_jhi_r <= sat32(rnd16(jhi_p));
      s2_alo_r <= sat32(rnd16(alo_p));
      s2_ahi_r <= sat32(rnd16(ahi_p));
      s3_in_r  <= s2_in_r;
      s3_v_r   <= vj_nxt;
      s3_alo_r <= s2_alo_r;
      s3_ahi_r <= s2_ahi_r;
      s4_req_r <= s3_in_r.requested_velocity;
      s4_v_r   <= vf_nxt;
    end
  end

  assign out_vld = s4_vld_r;
  assign out_req = s4_req_r;
  assign out_vel = s4_v_r;
endmodule

/* src/jav_ratio_div.sv */
// Pipelined restoring divider for the limited over requested ratio, one quotient bit a stage.
module jav_ratio_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  logic signed [31:0]  in_req,
  input  logic signed [31:0]  in_vel,
  output logic                out_vld,
  output jav_pkg::jav_out_t   out_item
);
  import jav_pkg::*;

  localparam int N = DivBits;

  logic [N-1:0]  vld_r;
  logic [N-1:0]  num_r [N];   // remaining dividend bits, shifted left
  logic [32:0]   rem_r [N];
  logic [N-1:0]  quo_r [N];
  logic [31:0]   den_r [N];
  logic          neg_r [N];
  logic          zero_r [N];
  logic signed [31:0] vel_r [N];

  logic [31:0]   vel_abs;
  logic [N-1:0]  num0;
  logic [31:0]   den0;
  logic [33:0]   trial0;

  always_comb begin
    vel_abs = in_vel[31] ? (~in_vel + 32'd1) : in_vel;
    num0    = N'({vel_abs, 16'd0});
    den0    = in_req[31] ? (~in_req + 32'd1) : in_req;
    trial0  = {33'd0, num0[N-1]} - {2'b0, den0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[N-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r[0]  <= num0 << 1;
      rem_r[0]  <= trial0[33] ? {32'd0, num0[N-1]} : trial0[32:0];
      quo_r[0]  <= {{(N-1){1'b0}}, ~trial0[33]};
      den_r[0]  <= den0;
      neg_r[0]  <= in_vel[31] ^ in_req[31];
      zero_r[0] <= (in_req == 32'sd0);
      vel_r[0]  <= in_vel;
      for (int i = 1; i < N; i++) begin
        logic [33:0] t;
        t = {rem_r[i-1], num_r[i-1][N-1]} - {2'b0, den_r[i-1]};
        num_r[i]  <= num_r[i-1] << 1;
        rem_r[i]  <= t[33] ? {rem_r[i-1][31:0], num_r[i-1][N-1]} : t[32:0];
        quo_r[i]  <= {quo_r[i-1][N-2:0], ~t[33]};
        den_r[i]  <= den_r[i-1];
        neg_r[i]  <= neg_r[i-1];
        zero_r[i] <= zero_r[i-1];
        vel_r[i]  <= vel_r[i-1];
      end
    end
  end

  logic signed [65:0] q_s;
  always_comb begin
    q_s = neg_r[N-1] ? -$signed({17'd0, quo_r[N-1]}) : $signed({17'd0, quo_r[N-1]});
    out_item.limited_velocity = vel_r[N-1];
    out_item.scale_factor     = zero_r[N-1] ? OneQ16 : sat32(q_s);
  end
  assign out_vld = vld_r[N-1];
endmodule

/* src/jav_checker.sv */
// Port level checks of the limiter, bound to the top level.
module jav_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [63:0] out_data
);
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with empty output");
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during stall");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind jerk_accel_velocity_limiter jav_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
